[hdl/shared_buffer_multi_queue_defines.svh]
`ifndef SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH
`define SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH

// Clocked assertion, off while rst is high.
`define SBMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds across reset.
`define SBMQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/sbmq_pkg.sv]
`default_nettype none

package sbmq_pkg;

  localparam int SLOTS  = 16;
  localparam int QUEUES = 4;
  localparam int DATA_W = 32;
  localparam int QID_W  = 2;
  localparam int PTR_W  = $clog2(SLOTS + 1);
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t NIL_PTR = PTR_W'(SLOTS);

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_FINISH
  } fsm_t;

  typedef struct packed {
    logic en;
    ptr_t addr;
    ptr_t data;
  } link_wr_t;

  typedef struct packed {
    logic en;
    ptr_t addr;
  } link_rd_t;

  function automatic logic ptr_ok(input ptr_t p);
    return p < NIL_PTR;
  endfunction

endpackage

`default_nettype wire

[hdl/sbmq_ram.sv]
`default_nettype none

module sbmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/sbmq_link_store.sv]
`default_nettype none

module sbmq_link_store (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sbmq_pkg::link_wr_t wr,
  input  wire sbmq_pkg::link_rd_t rd,
  output sbmq_pkg::ptr_t         rdata
);

  import sbmq_pkg::*;

  // Entries never written read as their reset link, i+1.
  logic [SLOTS-1:0] valid;
  logic             valid_rd;
  ptr_t             addr_rd;
  ptr_t             ram_rdata;

  sbmq_ram #(
    .WIDTH(PTR_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr[IDX_W-1:0]),
    .wdata(wr.data),
    .re   (rd.en),
    .raddr(rd.addr[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      valid_rd <= valid[rd.addr[IDX_W-1:0]];
      addr_rd  <= rd.addr;
    end
  end

  assign rdata = valid_rd ? ram_rdata : ptr_t'(addr_rd + PTR_W'(1));

endmodule

`default_nettype wire

[hdl/shared_buffer_multi_queue.sv]
`default_nettype none

// A transaction is accepted in S_IDLE and finished in S_FINISH, which waits
// while an unaccepted result is held; the result is registered at finish.
// No new input is taken until then: link read at accept, write-back at finish.
// Reset: all queues empty, free list holds every slot in order; the link
// memory is covered by per-entry valid bits, so no clearing pass is needed.
module shared_buffer_multi_queue (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                operation,
  input  wire logic [sbmq_pkg::QID_W-1:0]          queue_id,
  input  wire logic signed [sbmq_pkg::DATA_W-1:0]  push_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               status,
  output logic signed [sbmq_pkg::DATA_W-1:0]       pop_value
);

  import sbmq_pkg::*;

  fsm_t state, state_next;

  ptr_t              queue_head [QUEUES];
  ptr_t              queue_tail [QUEUES];
  ptr_t              free_head;

  op_t               op_r;
  logic [QIDX_W-1:0] q_r;
  logic              go_r;
  logic              head_null_r;
  ptr_t              slot_r;

  logic              accept;
  logic              finish;
  logic              q_ok;
  logic [QIDX_W-1:0] qi;
  ptr_t              cur_head;
  ptr_t              cur_tail;
  logic              push_go;
  logic              pop_go;

  link_wr_t          link_wr;
  link_rd_t          link_rd;
  ptr_t              link_rdata;

  logic              word_we;
  logic              word_re;
  logic [DATA_W-1:0] word_rdata;

  assign qi       = QIDX_W'(queue_id);
  assign q_ok     = int'(queue_id) < QUEUES;
  assign cur_head = queue_head[qi];
  assign cur_tail = queue_tail[qi];
  assign push_go  = (op_t'(operation) == OP_PUSH) && q_ok && ptr_ok(free_head);
  assign pop_go   = (op_t'(operation) == OP_POP) && q_ok && ptr_ok(cur_head);

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    finish     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Link memory: tail append at accept, write-back of the moved slot at finish.
  always_comb begin
    link_rd.en   = accept && (push_go || pop_go);
    link_rd.addr = (op_t'(operation) == OP_PUSH) ? free_head : cur_head;
    link_wr      = '0;
    if (finish) begin
      link_wr.en   = go_r;
      link_wr.addr = slot_r;
      link_wr.data = (op_r == OP_PUSH) ? NIL_PTR : free_head;
    end else begin
      link_wr.en   = accept && push_go && ptr_ok(cur_head) && ptr_ok(cur_tail);
      link_wr.addr = cur_tail;
      link_wr.data = free_head;
    end
  end

  sbmq_link_store u_link (
    .clk  (clk),
    .rst  (rst),
    .wr   (link_wr),
    .rd   (link_rd),
    .rdata(link_rdata)
  );

  assign word_we = accept && push_go;
  assign word_re = accept && pop_go;

  sbmq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(SLOTS)
  ) u_word (
    .clk  (clk),
    .we   (word_we),
    .waddr(free_head[IDX_W-1:0]),
    .wdata($unsigned(push_value)),
    .re   (word_re),
    .raddr(cur_head[IDX_W-1:0]),
    .rdata(word_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= op_t'(operation);
      q_r         <= qi;
      go_r        <= push_go || pop_go;
      head_null_r <= !ptr_ok(cur_head);
      slot_r      <= (op_t'(operation) == OP_PUSH) ? free_head : cur_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUES; i++) begin
        queue_head[i] <= NIL_PTR;
        queue_tail[i] <= NIL_PTR;
      end
      free_head <= '0;
    end else if (finish && go_r) begin
      if (op_r == OP_PUSH) begin
        free_head <= link_rdata;
        if (head_null_r) begin
          queue_head[q_r] <= slot_r;
        end
        queue_tail[q_r] <= slot_r;
      end else begin
        queue_head[q_r] <= link_rdata;
        free_head       <= slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (!go_r) begin
        status    <= (op_r == OP_PUSH) ? ST_FULL : ST_EMPTY;
        pop_value <= '0;
      end else if (op_r == OP_POP) begin
        status    <= ST_DONE;
        pop_value <= $signed(word_rdata);
      end else begin
        status    <= ST_DONE;
        pop_value <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/sbmq_checker.sv]
`default_nettype none

`include "shared_buffer_multi_queue_defines.svh"

module sbmq_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [1:0]                         status,
  input wire logic signed [sbmq_pkg::DATA_W-1:0] pop_value
);

  import sbmq_pkg::*;

  `SBMQ_ASSERT_RST(a_reset_clears_out, rst |=> !out_valid, "out_valid high after reset")
  `SBMQ_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
  `SBMQ_ASSERT(a_fail_zero, (out_valid && status != ST_DONE) |-> pop_value == '0, "nonzero data")
  `SBMQ_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(pop_value)), "result dropped")

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (.*);

`default_nettype wire

[sim/shared_buffer_multi_queue_tb.sv]
`default_nettype none

module shared_buffer_multi_queue_tb;
  import sbmq_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DIRECTED_ROWS = 25;
  localparam int PHASES = 13;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    status_t     st;
    logic [31:0] value;
  } reply_t;

  typedef struct {
    op_t         op;
    logic [1:0]  qid;
    logic [31:0] value;
    logic        known;
    status_t     exp_st;
    logic [31:0] exp_value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = 1'b0;
  logic [QID_W-1:0] queue_id = '0;
  logic signed [DATA_W-1:0] push_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic signed [DATA_W-1:0] pop_value;

  // tb-side tag traveling with the transaction: a typed-in expectation
  logic row_known = 1'b0;
  status_t row_st = ST_DONE;
  logic [31:0] row_value = '0;

  logic no_idle = 1'b0;
  int quiet_cycles = 0;
  int errors = 0;

  reply_t awaited_replies[$];

  ptr_t q_head[QUEUES];
  ptr_t q_tail[QUEUES];
  ptr_t slot_next[SLOTS];
  logic [31:0] slot_data[SLOTS];
  ptr_t free_ptr;

  stim_row_t directed[DIRECTED_ROWS];

  shared_buffer_multi_queue u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .queue_id   (queue_id),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .pop_value  (pop_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic reply_t apply_queue_op(op_t op, logic [1:0] q, logic [31:0] v);
    reply_t r;
    ptr_t s;
    r.st = ST_DONE;
    r.value = '0;
    if (op == OP_PUSH) begin
      if (int'(q) >= QUEUES || free_ptr >= NIL_PTR) begin
        r.st = ST_FULL;
      end else begin
        s = free_ptr;
        free_ptr = slot_next[s];
        if (q_head[q] >= NIL_PTR) begin
          q_head[q] = s;
        end else if (q_tail[q] < NIL_PTR) begin
          slot_next[q_tail[q]] = s;
        end
        slot_next[s] = NIL_PTR;
        q_tail[q] = s;
        slot_data[s] = v;
      end
    end else begin
      if (int'(q) >= QUEUES || q_head[q] >= NIL_PTR) begin
        r.st = ST_EMPTY;
      end else begin
        s = q_head[q];
        q_head[q] = slot_next[s];
        slot_next[s] = free_ptr;
        free_ptr = s;
        r.value = slot_data[s];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < QUEUES; i++) begin
        q_head[i] = NIL_PTR;
        q_tail[i] = NIL_PTR;
      end
      for (int i = 0; i < SLOTS; i++) begin
        slot_next[i] = (i == SLOTS - 1) ? NIL_PTR : ptr_t'(i + 1);
        slot_data[i] = '0;
      end
      free_ptr = '0;
      awaited_replies.delete();
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $error("result with nothing pending: status %0d, pop_value %h", status, pop_value);
          errors++;
        end else begin
          want = awaited_replies.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            errors++;
          end
          if (pop_value !== want.value) begin
            $error("pop_value: expected %h, got %h", want.value, pop_value);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = apply_queue_op(op_t'(operation), queue_id, push_value);
        if (row_known) begin
          want.st = row_st;
          want.value = row_value;
        end
        awaited_replies.push_back(want);
      end
      quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0
                      : quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 28);
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("shared_buffer_multi_queue: mismatch");
    $finish;
  end

  task automatic send_item(input op_t op, input logic [1:0] q, input logic [31:0] v,
                           input logic known, input status_t st, input logic [31:0] pv);
    while (!no_idle && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    queue_id   <= q;
    push_value <= v;
    row_known  <= known;
    row_st     <= st;
    row_value  <= pv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait past the current edge first, so the transaction accepted there is queued
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    int push_pct;
    int focus_q;
    logic [1:0] qsel;
    logic [31:0] v;
    op_t op;

    directed[0] = '{OP_POP,  2'd0, 32'h0,         1'b1, ST_EMPTY, 32'h0};
    directed[1] = '{OP_POP,  2'd3, 32'hffff_ffff, 1'b1, ST_EMPTY, 32'h0};
    directed[2] = '{OP_PUSH, 2'd0, 32'h7fff_ffff, 1'b1, ST_DONE,  32'h0};
    directed[3] = '{OP_PUSH, 2'd0, 32'h8000_0000, 1'b1, ST_DONE,  32'h0};
    directed[4] = '{OP_POP,  2'd0, 32'h0,         1'b1, ST_DONE,  32'h7fff_ffff};
    directed[5] = '{OP_POP,  2'd0, 32'h0,         1'b1, ST_DONE,  32'h8000_0000};
    directed[6] = '{OP_POP,  2'd0, 32'h0,         1'b1, ST_EMPTY, 32'h0};
    // queue 0 drained: tail is stale, next push must restart from head
    directed[7] = '{OP_PUSH, 2'd0, 32'hffff_ffff, 1'b1, ST_DONE,  32'h0};
    for (int i = 0; i < SLOTS - 1; i++) begin
      directed[8 + i] = '{OP_PUSH, 2'(1 + i % 3), 32'h0101_0101 * (i + 1), 1'b0,
                          ST_DONE, 32'h0};
    end
    directed[23] = '{OP_PUSH, 2'd2, 32'h1234_5678, 1'b1, ST_FULL, 32'h0};
    directed[24] = '{OP_POP,  2'd0, 32'h0,         1'b1, ST_DONE, 32'hffff_ffff};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].qid, directed[i].value,
                directed[i].known, directed[i].exp_st, directed[i].exp_value);
    end
    drain_replies();

    for (int ph = 0; ph < PHASES; ph++) begin
      no_idle <= (ph == 5);
      case (ph % 4)
        0:       push_pct = 85;
        1:       push_pct = 50;
        2:       push_pct = 15;
        default: push_pct = $urandom_range(100);
      endcase
      focus_q = (ph % 3 == 1) ? int'($urandom_range(QUEUES - 1)) : -1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        qsel = (focus_q >= 0 && $urandom_range(3) != 0) ? 2'(focus_q)
               : 2'($urandom_range(QUEUES - 1));
        case ($urandom_range(9))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
          default: v = $urandom();
        endcase
        send_item(op, qsel, v, 1'b0, ST_DONE, 32'h0);
      end
      if (ph == 6) drain_replies();
    end

    drain_replies();
    repeat (6) @(posedge clk);
    if (errors == 0 && awaited_replies.size() == 0) begin
      $display("shared_buffer_multi_queue: match");
    end else begin
      $display("shared_buffer_multi_queue: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/sbmq_pkg.sv
hdl/sbmq_ram.sv
hdl/sbmq_link_store.sv
hdl/shared_buffer_multi_queue.sv
hdl/sbmq_checker.sv
sim/shared_buffer_multi_queue_tb.sv
